/* rtl/pqd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqd_pkg: shared types and constants of the PQ distance engine
// Table geometry, beat structs, register indexes and arithmetic widths.
// ----------------------------------------------------------------------------
package pqd_pkg;

  localparam int MAX_CHUNKS  = 64;
  localparam int CENTROIDS   = 16;
  localparam int CENT_W      = $clog2(CENTROIDS);
  localparam int TABLE_DEPTH = MAX_CHUNKS * CENTROIDS;

  // Byte position counts code bytes and stops one past the last useful byte.
  localparam int POS_CAP = (MAX_CHUNKS + 1) / 2;
  localparam int POS_W   = $clog2(POS_CAP + 1);

  // Even and odd subspaces live in separate banks.
  localparam int BANK_DEPTH = POS_CAP * CENTROIDS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Chunk compare width: covers num_chunks, MAX_CHUNKS and sub index + 1.
  localparam int CMP_W = ($clog2(MAX_CHUNKS + 3) > 7) ? $clog2(MAX_CHUNKS + 3) : 8;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 8;
  localparam int CODE_W  = 8;
  localparam int NCH_W   = 7;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W   = 14;
  localparam int DIST_W  = 48;
  localparam int PROD_W  = SUM_W + CFG_W;

  localparam logic [CODE_W-1:0] NIBBLE_MASK = 8'h0F;
  localparam logic [SUM_W-1:0]  SUM_MAX     = {SUM_W{1'b1}};
  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CHUNKS  = 2'd0,
    CFG_SCALE_DELTA = 2'd1,
    CFG_OFFSET_BIAS = 2'd2
  } pqd_cfg_idx_e;

  typedef enum logic {
    OP_TABLE_WRITE = 1'b0,
    OP_CODE_BYTE   = 1'b1
  } pqd_op_e;

  typedef struct packed {
    pqd_op_e           op;
    logic [IDX_W-1:0]  table_index;
    logic [VAL_W-1:0]  table_value;
    logic [CODE_W-1:0] code_byte;
    logic              last;
  } pqd_in_t;

  typedef struct packed {
    logic [SUM_W-1:0]         sum_units;
    logic signed [DIST_W-1:0] distance;
  } pqd_out_t;

  typedef struct packed {
    logic [CFG_W-1:0]        delta;
    logic signed [CFG_W-1:0] bias;
  } pqd_scale_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } pqd_sum_beat_t;

endpackage

/* rtl/pq_adc_u8_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pq_adc_u8_distance: asymmetric PQ distance engine for 4-bit codes
// Table writes fill two banked RAMs; code bytes look up two nibbles per beat,
// accumulate, and the last byte of a code yields sum and scaled distance.
// ----------------------------------------------------------------------------
// Throughput: one beat (table write or code byte) per cycle while the input
//   is not stalled. Result path of a last code byte: RAM read, accumulate into
//   the sum register, multiply, then bias add and saturate into the output.
// Input stalls only while a last byte waits behind three held results.
// Reset: control, registers and running sum clear at once; the distance table
//   holds no defined value until written and gets no clearing pass.
// ----------------------------------------------------------------------------
module pq_adc_u8_distance (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pqd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pqd_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pqd_pkg::pqd_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pqd_pkg::pqd_out_t              out_data_o
);
  import pqd_pkg::*;

  // Configuration registers.
  logic [NCH_W-1:0]        num_chunks_q;
  logic [CFG_W-1:0]        scale_delta_q;
  logic signed [CFG_W-1:0] offset_bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_chunks_q  <= NCH_W'(1);
      scale_delta_q <= '0;
      offset_bias_q <= '0;
    end else if (cfg_we_i) begin
      case (pqd_cfg_idx_e'(cfg_index_i))
        CFG_NUM_CHUNKS:  num_chunks_q  <= cfg_wdata_i[NCH_W-1:0];
        CFG_SCALE_DELTA: scale_delta_q <= cfg_wdata_i;
        CFG_OFFSET_BIAS: offset_bias_q <= cfg_wdata_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Input handshake.
  logic accept;
  logic code_acc;
  logic tw_acc;

  assign accept   = in_valid_i && !in_stall_o;
  assign code_acc = accept && (in_data_i.op == OP_CODE_BYTE);
  // Ignore table writes past the end of the table.
  assign tw_acc   = accept && (in_data_i.op == OP_TABLE_WRITE)
                 && (32'(in_data_i.table_index) < TABLE_DEPTH);

  // Table banks: even subspaces in the low bank, odd in the high bank, so
  // both nibbles of one byte read in the same cycle.
  logic               we_lo, we_hi;
  logic [BANK_AW-1:0] waddr;
  logic [BANK_AW-1:0] raddr_lo, raddr_hi;
  logic [VAL_W-1:0]   rdata_lo, rdata_hi;
  logic [POS_W-1:0]   pos_q, pos_d;

  assign we_lo = tw_acc && !in_data_i.table_index[CENT_W];
  assign we_hi = tw_acc &&  in_data_i.table_index[CENT_W];
  assign waddr = (BANK_AW'(in_data_i.table_index >> (CENT_W + 1)) << CENT_W)
               | BANK_AW'(in_data_i.table_index[CENT_W-1:0]);

  // Byte position p selects row p of both banks; the nibble picks the centroid.
  assign raddr_lo = (BANK_AW'(pos_q) << CENT_W)
                  | BANK_AW'(in_data_i.code_byte & NIBBLE_MASK);
  assign raddr_hi = (BANK_AW'(pos_q) << CENT_W)
                  | BANK_AW'(in_data_i.code_byte >> CENT_W);

  pqd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_lo (
    .clk_i   (clk_i),
    .we_i    (we_lo),
    .waddr_i (waddr),
    .wdata_i (in_data_i.table_value),
    .re_i    (code_acc),
    .raddr_i (raddr_lo),
    .rdata_o (rdata_lo)
  );

  pqd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_hi (
    .clk_i   (clk_i),
    .we_i    (we_hi),
    .waddr_i (waddr),
    .wdata_i (in_data_i.table_value),
    .re_i    (code_acc),
    .raddr_i (raddr_hi),
    .rdata_o (rdata_hi)
  );

  // Chunk limit: counts above MAX_CHUNKS act as MAX_CHUNKS.
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] sub_lo;
  logic             en_lo, en_hi;

  assign limit  = (CMP_W'(num_chunks_q) > CMP_W'(MAX_CHUNKS)) ? CMP_W'(MAX_CHUNKS)
                                                              : CMP_W'(num_chunks_q);
  assign sub_lo = CMP_W'(pos_q) << 1;
  assign en_lo  = sub_lo < limit;
  assign en_hi  = (sub_lo + CMP_W'(1)) < limit;

  // Advance the byte position, hold it once past the last useful byte, and
  // restart it on the last byte of a code.
  always_comb begin
    pos_d = pos_q;
    if (code_acc) begin
      if (in_data_i.last) begin
        pos_d = '0;
      end else if (32'(pos_q) < POS_CAP) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  // Lookup stage: holds a code beat while its RAM data is out.
  logic s1_valid_q, s1_valid_d;
  logic s1_last_q;
  logic s1_en_lo_q, s1_en_hi_q;
  logic s1_fire;
  logic scale_ready;

  logic [SUM_W-1:0]   running_sum_q, running_sum_d;
  logic [SUM_W+1:0]   sum_ext;
  logic [SUM_W-1:0]   new_sum;
  pqd_sum_beat_t      sum_beat;

  // Non-last bytes always drain; a last byte needs room in the scale stage.
  assign s1_fire    = s1_valid_q && (!s1_last_q || scale_ready);
  assign in_stall_o = s1_valid_q && !s1_fire;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (code_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end

    // Add both nibbles and saturate at the top of the sum range.
    sum_ext = (SUM_W + 2)'(running_sum_q)
            + (s1_en_lo_q ? (SUM_W + 2)'(rdata_lo) : '0)
            + (s1_en_hi_q ? (SUM_W + 2)'(rdata_hi) : '0);
    new_sum = (sum_ext > (SUM_W + 2)'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];

    running_sum_d = running_sum_q;
    if (s1_fire) begin
      running_sum_d = s1_last_q ? '0 : new_sum;
    end

    sum_beat.valid = s1_valid_q && s1_last_q;
    sum_beat.sum   = new_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      s1_valid_q    <= 1'b0;
      s1_last_q     <= 1'b0;
      s1_en_lo_q    <= 1'b0;
      s1_en_hi_q    <= 1'b0;
      running_sum_q <= '0;
    end else begin
      pos_q         <= pos_d;
      s1_valid_q    <= s1_valid_d;
      running_sum_q <= running_sum_d;
      if (code_acc) begin
        s1_last_q  <= in_data_i.last;
        s1_en_lo_q <= en_lo;
        s1_en_hi_q <= en_hi;
      end
    end
  end

  // Scale, bias, saturate and deliver the result beat.
  pqd_scale_cfg_t scale_cfg;

  assign scale_cfg.delta = scale_delta_q;
  assign scale_cfg.bias  = offset_bias_q;

  pqd_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (scale_cfg),
    .beat_i      (sum_beat),
    .ready_o     (scale_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Assertions.
  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_last_q && !scale_ready))
    else $error("input stalled without a blocked last byte");

  a_pos_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= POS_CAP)
    else $error("byte position ran past its cap");

  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_acc && in_data_i.last) |=> (pos_q == '0))
    else $error("byte position not restarted after last byte");

  a_sum_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> (running_sum_q == '0))
    else $error("running sum not cleared after last byte");

endmodule

/* rtl/pqd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pqd_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqd_scale: sum scaling and output stage
// Registers the code sum, multiplies by delta, adds bias, saturates to 48 bits.
// ----------------------------------------------------------------------------
module pqd_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pqd_pkg::pqd_scale_cfg_t cfg_i,
  input  pqd_pkg::pqd_sum_beat_t  beat_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output pqd_pkg::pqd_out_t       out_data_o
);
  import pqd_pkg::*;

  logic              a_valid_q, a_valid_d;
  logic [SUM_W-1:0]  a_sum_q;
  logic              b_valid_q, b_valid_d;
  logic [SUM_W-1:0]  b_sum_q;
  logic [PROD_W-1:0] b_prod_q, b_prod_d;
  logic              o_valid_q, o_valid_d;
  pqd_out_t          o_data_q, o_data_d;

  logic a_ready, b_ready, o_ready;
  logic signed [DIST_W:0] dist_ext;

  // Each stage moves when its successor is empty or moving.
  assign o_ready = !o_valid_q || !out_stall_i;
  assign b_ready = !b_valid_q || o_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  always_comb begin
    a_valid_d = a_ready ? beat_i.valid : a_valid_q;
    b_valid_d = b_ready ? a_valid_q : b_valid_q;
    o_valid_d = o_ready ? b_valid_q : o_valid_q;

    b_prod_d = PROD_W'(a_sum_q) * PROD_W'(cfg_i.delta);

    dist_ext = $signed({{(DIST_W + 1 - PROD_W){1'b0}}, b_prod_q})
             + (DIST_W + 1)'(cfg_i.bias);
    o_data_d.sum_units = b_sum_q;
    case (dist_ext[DIST_W:DIST_W-1])
      2'b01:   o_data_d.distance = DIST_MAX;
      2'b10:   o_data_d.distance = DIST_MIN;
      default: o_data_d.distance = dist_ext[DIST_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && beat_i.valid) begin
      a_sum_q <= beat_i.sum;
    end
    if (b_ready && a_valid_q) begin
      b_sum_q  <= a_sum_q;
      b_prod_q <= b_prod_d;
    end
    if (o_ready && b_valid_q) begin
      o_data_q <= o_data_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

endmodule

/* tb/pq_adc_u8_distance_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pq_adc_u8_distance_tb: self-checking bench for the PQ distance engine
// Loads distance table entries and streams 4-bit code vectors under several
// register settings and handshake pressure. Each result beat is compared
// field by field against an in-bench model of the table lookup, the sum and
// the scaled, biased and saturated distance.
// ----------------------------------------------------------------------------
module pq_adc_u8_distance_tb;
  import pqd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;    // settle time after the last pending result
  localparam int HOLD_CYCLES  = 300;  // long sink hold-off to back up the pipeline
  localparam int PHASE_BEATS  = 85;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors table, running sum, byte position and registers;
  // queues the expected result of every last code byte.
  // --------------------------------------------------------------------------
  class pq_distance_scoreboard;
    logic [VAL_W-1:0]  entry_value [TABLE_DEPTH];
    bit                entry_loaded [TABLE_DEPTH];
    logic [SUM_W-1:0]  acc_sum;
    int unsigned       acc_pos;
    logic [NCH_W-1:0]  chunks;
    logic [CFG_W-1:0]  delta;
    logic signed [CFG_W-1:0] bias;
    pqd_out_t          expected_dist_q [$];
    int unsigned       mismatches;

    function new();
      foreach (entry_value[i]) begin
        entry_value[i]  = '0;
        entry_loaded[i] = 1'b0;
      end
      acc_sum    = '0;
      acc_pos    = 0;
      chunks     = NCH_W'(1);
      delta      = '0;
      bias       = '0;
      mismatches = 0;
    endfunction

    function void set_reg(pqd_cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_NUM_CHUNKS:  chunks = val[NCH_W-1:0];
        CFG_SCALE_DELTA: delta  = val;
        CFG_OFFSET_BIAS: bias   = val;
        default: ;
      endcase
    endfunction

    // Counts above MAX_CHUNKS behave as MAX_CHUNKS.
    function int unsigned active_chunks();
      return (chunks > MAX_CHUNKS) ? MAX_CHUNKS : int'(chunks);
    endfunction

    function bit subspace_loaded(int unsigned sub);
      for (int c = 0; c < CENTROIDS; c++) begin
        if (entry_loaded[sub * CENTROIDS + c]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void add_lookup(int unsigned sub, logic [CENT_W-1:0] cent, int unsigned lim);
      int unsigned addr;
      int unsigned total;
      if (sub >= lim) return;
      addr = sub * CENTROIDS + cent;
      if (addr >= TABLE_DEPTH) return;
      total   = acc_sum + entry_value[addr];
      acc_sum = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
    endfunction

    // Exact sum * delta + bias, clamped to the signed 48-bit range.
    function logic signed [DIST_W-1:0] scaled_distance(logic [SUM_W-1:0] s);
      logic [63:0] prod;
      longint      d;
      prod = 64'(s) * 64'(delta);
      d    = longint'(prod) + longint'(bias);
      if (d > longint'(DIST_MAX)) d = longint'(DIST_MAX);
      if (d < longint'(DIST_MIN)) d = longint'(DIST_MIN);
      return d[DIST_W-1:0];
    endfunction

    function void note_beat(pqd_in_t b);
      int unsigned lim;
      pqd_out_t    res;
      if (b.op == OP_TABLE_WRITE) begin
        if (b.table_index < TABLE_DEPTH) begin
          entry_value[b.table_index]  = b.table_value;
          entry_loaded[b.table_index] = 1'b1;
        end
        return;
      end
      lim = active_chunks();
      add_lookup(acc_pos * 2,     b.code_byte[3:0], lim);
      add_lookup(acc_pos * 2 + 1, b.code_byte[7:4], lim);
      if (acc_pos < POS_CAP) acc_pos++;
      if (b.last) begin
        res.sum_units = acc_sum;
        res.distance  = scaled_distance(acc_sum);
        expected_dist_q.push_back(res);
        acc_sum = '0;
        acc_pos = 0;
      end
    endfunction

    function void flag(string what, longint exp_v, longint got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, got_v);
    endfunction

    function void check_result(pqd_out_t got);
      pqd_out_t exp_r;
      if (expected_dist_q.size() == 0) begin
        flag("unexpected result, sum_units", -1, longint'(got.sum_units));
        return;
      end
      exp_r = expected_dist_q.pop_front();
      if (got.sum_units !== exp_r.sum_units)
        flag("sum_units", longint'(exp_r.sum_units), longint'(got.sum_units));
      if (got.distance !== exp_r.distance)
        flag("distance", longint'(exp_r.distance), longint'(got.distance));
    endfunction

    function int pending();
      return expected_dist_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals: every input known from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  pqd_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  pqd_out_t              out_data_o;

  pq_distance_scoreboard sb;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_cycles    = 0;
  int unsigned beats_sent     = 0;
  int unsigned cycle_count    = 0;

  always #10 clk_i = ~clk_i;

  pq_adc_u8_distance i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // --------------------------------------------------------------------------
  // Beat builders: fields unused by the operation carry random junk
  // --------------------------------------------------------------------------
  function automatic pqd_in_t table_beat(int unsigned idx, int unsigned val);
    pqd_in_t b;
    b.op          = OP_TABLE_WRITE;
    b.table_index = idx[IDX_W-1:0];
    b.table_value = val[VAL_W-1:0];
    b.code_byte   = CODE_W'($urandom);
    b.last        = 1'($urandom);   // ignored on table writes
    return b;
  endfunction

  function automatic pqd_in_t code_beat(logic [CODE_W-1:0] code, bit is_last);
    pqd_in_t b;
    b.op          = OP_CODE_BYTE;
    b.table_index = IDX_W'($urandom);
    b.table_value = VAL_W'($urandom);
    b.code_byte   = code;
    b.last        = is_last;
    return b;
  endfunction

  // Favor the extremes of an 8-bit distance.
  function automatic int unsigned pick_value();
    case ($urandom_range(9))
      0, 1:    return 255;
      2:       return 0;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic logic [NCH_W-1:0] pick_chunks();
    case ($urandom_range(9))
      0:       return NCH_W'(0);
      1:       return NCH_W'(1);
      2:       return NCH_W'(2);
      3:       return NCH_W'(63);
      4:       return NCH_W'(64);
      5:       return NCH_W'(65);
      6:       return NCH_W'(127);
      default: return NCH_W'($urandom_range(1, MAX_CHUNKS));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_delta();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h0001_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_bias();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input driver. Valid stays high after an accepted beat; the next call
  // either replaces the payload in the same step or drops valid for a gap.
  // --------------------------------------------------------------------------
  task automatic send_beat(input pqd_in_t beat);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    // Hold the payload until an edge sees no stall.
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    sb.note_beat(beat);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers back to back; only called while idle.
  // Upper bits of the chunk count are junk and must be dropped by the block.
  task automatic write_regs(logic [NCH_W-1:0] nch, logic [CFG_W-1:0] delta,
                            logic [CFG_W-1:0] bias);
    logic [CFG_W-1:0] nch_word;
    nch_word = {25'($urandom), nch};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_NUM_CHUNKS;
    cfg_wdata_i <= nch_word;
    @(posedge clk_i);
    cfg_index_i <= CFG_SCALE_DELTA;
    cfg_wdata_i <= delta;
    @(posedge clk_i);
    cfg_index_i <= CFG_OFFSET_BIAS;
    cfg_wdata_i <= bias;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(CFG_NUM_CHUNKS, nch_word);
    sb.set_reg(CFG_SCALE_DELTA, delta);
    sb.set_reg(CFG_OFFSET_BIAS, bias);
  endtask

  // Send one code byte. Every nibble that lands in an active subspace picks a
  // loaded centroid; load one first if the subspace has none yet.
  task automatic send_code(bit is_last);
    logic [CENT_W-1:0] nib [2];
    int unsigned sub;
    int unsigned c;
    for (int j = 0; j < 2; j++) begin
      sub = sb.acc_pos * 2 + j;
      if (sub < sb.active_chunks()) begin
        if (!sb.subspace_loaded(sub))
          send_beat(table_beat(sub * CENTROIDS + $urandom_range(CENTROIDS - 1), pick_value()));
        c = $urandom_range(CENTROIDS - 1);
        while (!sb.entry_loaded[sub * CENTROIDS + c]) c = (c + 1) % CENTROIDS;
        nib[j] = c[CENT_W-1:0];
      end else begin
        nib[j] = CENT_W'($urandom);
      end
    end
    send_beat(code_beat({nib[1], nib[0]}, is_last));
  endtask

  // One code vector: usually the exact length for the chunk count, sometimes
  // short or running past the position cap; table writes may slip in.
  task automatic send_code_vector();
    int unsigned len;
    len = (sb.active_chunks() + 1) / 2;
    if (len == 0) len = 1;
    if ($urandom_range(99) < 15) len = $urandom_range(1, POS_CAP + 4);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(99) < 8)
        send_beat(table_beat($urandom_range(TABLE_DEPTH - 1), pick_value()));
      send_code(k == len - 1);
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned goal;
    int unsigned r;
    goal = beats_sent + count;
    while (beats_sent < goal) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_code_vector();
      end else if (r < 90) begin
        repeat ($urandom_range(1, 8))
          send_beat(table_beat($urandom_range(TABLE_DEPTH - 1), pick_value()));
      end else begin
        // Stray byte with random last: breaks or ends a vector early.
        send_code(1'($urandom));
      end
      // Now and then pause the source until the sink has caught up.
      if ($urandom_range(199) == 0) wait_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: check at the edge, then pick the stall for the next cycle
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) sb.check_result(out_data_o);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if the pipeline hangs
  // --------------------------------------------------------------------------
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("pq_adc_u8_distance test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: one chunk, zero delta, zero bias.
    send_beat(table_beat(15, 255));
    send_beat(table_beat(0, 0));
    send_code(1'b1);                      // keep the generator honest
    send_beat(code_beat(8'h0F, 1'b1));    // largest entry, odd nibble ignored
    send_beat(code_beat(8'hF0, 1'b1));
    send_beat(code_beat(8'h0F, 1'b0));    // second byte lies past the chunks
    send_beat(code_beat(8'h5A, 1'b1));

    // Delta of 0x10000, most negative bias; table rewrites inside a vector.
    wait_drained();
    write_regs(NCH_W'(2), 32'h0001_0000, 32'h8000_0000);
    send_beat(table_beat(19, 200));
    send_beat(code_beat(8'h3F, 1'b1));
    send_beat(code_beat(8'h30, 1'b0));
    send_beat(table_beat(19, 1));
    send_beat(table_beat(0, 77));
    send_beat(code_beat(8'h00, 1'b1));
    send_beat(code_beat(8'h30, 1'b1));    // sees both rewrites

    // Zero chunks: distance is the bias alone.
    wait_drained();
    write_regs(NCH_W'(0), 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_beat(code_beat(8'hFF, 1'b1));

    // Oversized chunk count, largest delta; writes to the last table address and to 512.
    wait_drained();
    write_regs(NCH_W'(127), 32'hFFFF_FFFF, 32'h8000_0000);
    send_beat(code_beat(8'h3F, 1'b1));
    send_beat(table_beat(TABLE_DEPTH - 1, 255));
    send_beat(table_beat(512, 0));

    // Random part: three idle profiles, several register settings each.
    for (int mode = 0; mode < 3; mode++) begin
      for (int ph = 0; ph < 6; ph++) begin
        wait_drained();
        case (mode)
          0: begin src_idle_pct = 23; sink_stall_pct = 71; end
          1: begin src_idle_pct = 71; sink_stall_pct = 23; end
          default: begin src_idle_pct = 0; sink_stall_pct = 0; end
        endcase
        if (mode == 2 && ph == 0) begin
          // One-byte vectors against a long sink hold-off: fill the block
          // until it stalls its input.
          write_regs(NCH_W'(2), pick_delta(), pick_bias());
          hold_cycles = HOLD_CYCLES;
        end else if (ph == 0) begin
          write_regs(NCH_W'(MAX_CHUNKS), 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        end else if (ph == 1) begin
          write_regs(NCH_W'(1), 32'h0000_0000, 32'h8000_0000);
        end else begin
          write_regs(pick_chunks(), pick_delta(), pick_bias());
        end
        run_random(PHASE_BEATS);
      end
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("pq_adc_u8_distance test passed");
    end else begin
      $display("pq_adc_u8_distance test failed");
    end
    $finish;
  end

endmodule

/* pq_adc_u8_distance.f */
rtl/pqd_pkg.sv
rtl/pqd_ram.sv
rtl/pqd_scale.sv
rtl/pq_adc_u8_distance.sv
tb/pq_adc_u8_distance_tb.sv
